/* rtl/psbz_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pulse conditioning package
// Shared types, register indexes, filter coefficients and rounding helpers.
// ----------------------------------------------------------------------------
package psbz_pkg;

  localparam int SECTION_COUNT = 2;
  localparam int SECT_W = $clog2(SECTION_COUNT);

  localparam logic [7:0] REG_SMOOTHING_ALPHA = 8'd0;
  localparam logic [7:0] REG_MIN_SAMPLES = 8'd1;

  localparam int COEF_B0 = 0;
  localparam int COEF_B1 = 1;
  localparam int COEF_B2 = 2;
  localparam int COEF_A1 = 3;
  localparam int COEF_A2 = 4;

  localparam logic signed [29:0] COEF [SECTION_COUNT][5] = '{
    '{30'sd46999731, 30'sd93999463, 30'sd46999731, -30'sd127073441, 30'sd69981414},
    '{30'sd268435456, -30'sd536870912, 30'sd268435456, -30'sd490074532, 30'sd226170588}
  };

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_SM_MUL1, OP_SM_MUL2, OP_SM_DONE,
    OP_BQ_M0, OP_BQ_Y, OP_BQ_M1, OP_BQ_T1, OP_BQ_M3, OP_BQ_D0,
    OP_BQ_M2, OP_BQ_T2, OP_BQ_M4, OP_BQ_D1,
    OP_WIN_RD, OP_SQ_OLD, OP_SUB_OLD, OP_SQ_NEW, OP_ADD_NEW,
    OP_MEAN_DIV, OP_VAR_DIV, OP_MSQ, OP_VAR, OP_Z_DIV, OP_FINISH, OP_OUT
  } op_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_SM_MUL1, ST_SM_MUL2, ST_SM_DONE,
    ST_BQ_M0, ST_BQ_Y, ST_BQ_M1, ST_BQ_T1, ST_BQ_M3, ST_BQ_D0,
    ST_BQ_M2, ST_BQ_T2, ST_BQ_M4, ST_BQ_D1,
    ST_WIN_RD, ST_SQ_OLD, ST_SUB_OLD, ST_SQ_NEW, ST_ADD_NEW, ST_CHECK,
    ST_MEAN_DIV, ST_MEAN_WAIT, ST_VAR_WAIT, ST_MSQ, ST_VAR, ST_SQRT_WAIT,
    ST_Z_WAIT, ST_FINISH, ST_OUT
  } state_t;

  typedef struct packed {
    op_t op;
    logic [SECT_W-1:0] sect;
  } psbz_cmd_t;

  typedef struct packed {
    logic started;
    logic z_en;
    logic div_busy;
    logic sqrt_busy;
  } psbz_sts_t;

  function automatic logic signed [35:0] round_q28(input logic signed [63:0] p);
    logic [63:0] m;
    logic [63:0] r;
    m = p[63] ? 64'(-p) : 64'(p);
    r = (m + 64'd134217728) >> 28;
    return p[63] ? -$signed(r[35:0]) : $signed(r[35:0]);
  endfunction

  function automatic logic signed [31:0] sat_to_32(input logic signed [47:0] v);
    if (v > 48'sd2147483647) begin
      return 32'sh7FFFFFFF;
    end else if (v < -48'sd2147483648) begin
      return 32'sh80000000;
    end
    return $signed(v[31:0]);
  endfunction

  function automatic logic signed [39:0] sat_to_40(input logic signed [47:0] v);
    if (v > 48'sd549755813887) begin
      return 40'sh7FFFFFFFFF;
    end else if (v < -48'sd549755813888) begin
      return 40'sh8000000000;
    end
    return $signed(v[39:0]);
  endfunction

endpackage

/* rtl/psbz_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bit-serial divider
// Unsigned restoring division of a 64-bit dividend, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module psbz_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [31:0] divisor,
  output logic [63:0] quotient,
  output logic        busy
);

  logic [31:0] rem;
  logic [31:0] dvs;
  logic [5:0]  count;
  logic [32:0] trial;
  logic        ge;

  assign trial = {rem, quotient[63]};
  assign ge = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      count <= '0;
    end else if (start) begin
      busy <= 1'b1;
      count <= 6'd63;
      rem <= '0;
      dvs <= divisor;
      quotient <= dividend;
    end else if (busy) begin
      rem <= ge ? 32'(trial - {1'b0, dvs}) : trial[31:0];
      quotient <= {quotient[62:0], ge};
      count <= count - 6'd1;
      if (count == 6'd0) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

/* rtl/psbz_sqrt.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bit-serial square root
// Floor square root of a 64-bit value, one result bit a cycle.
// ----------------------------------------------------------------------------
module psbz_sqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] value,
  output logic [31:0] root,
  output logic        busy
);

  logic [63:0] v;
  logic [63:0] res;
  logic [63:0] bitv;
  logic [63:0] trial;

  assign trial = res + bitv;
  assign root = res[31:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      res <= '0;
    end else if (start) begin
      busy <= 1'b1;
      v <= value;
      res <= '0;
      bitv <= 64'h4000_0000_0000_0000;
    end else if (busy) begin
      if (v >= trial) begin
        v <= v - trial;
        res <= (res >> 1) + bitv;
      end else begin
        res <= res >> 1;
      end
      bitv <= bitv >> 2;
      if (bitv == 64'd1) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

/* rtl/psbz_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pulse conditioning controller
// Sequences smoothing, filter sections, window update and z-score per item.
// ----------------------------------------------------------------------------
module psbz_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 sample_valid,
  output logic                 sample_stall,
  output logic                 result_valid,
  input  logic                 result_stall,
  input  psbz_pkg::psbz_sts_t  sts,
  output psbz_pkg::psbz_cmd_t  cmd
);
  import psbz_pkg::*;

  state_t state;
  state_t state_next;
  logic [SECT_W-1:0] sect;
  logic out_load;

  assign out_load = !result_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      sect <= '0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_IDLE) begin
        sect <= '0;
      end else if (state == ST_BQ_D1) begin
        sect <= sect + 1'b1;
      end
      if (state == ST_OUT && out_load) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (sample_valid) begin
          state_next = sts.started ? ST_SM_MUL1 : ST_BQ_M0;
        end
      end
      ST_SM_MUL1: state_next = ST_SM_MUL2;
      ST_SM_MUL2: state_next = ST_SM_DONE;
      ST_SM_DONE: state_next = ST_BQ_M0;
      ST_BQ_M0: state_next = ST_BQ_Y;
      ST_BQ_Y: state_next = ST_BQ_M1;
      ST_BQ_M1: state_next = ST_BQ_T1;
      ST_BQ_T1: state_next = ST_BQ_M3;
      ST_BQ_M3: state_next = ST_BQ_D0;
      ST_BQ_D0: state_next = ST_BQ_M2;
      ST_BQ_M2: state_next = ST_BQ_T2;
      ST_BQ_T2: state_next = ST_BQ_M4;
      ST_BQ_M4: state_next = ST_BQ_D1;
      ST_BQ_D1: begin
        state_next = (sect == SECT_W'(SECTION_COUNT - 1)) ? ST_WIN_RD : ST_BQ_M0;
      end
      ST_WIN_RD: state_next = ST_SQ_OLD;
      ST_SQ_OLD: state_next = ST_SUB_OLD;
      ST_SUB_OLD: state_next = ST_SQ_NEW;
      ST_SQ_NEW: state_next = ST_ADD_NEW;
      ST_ADD_NEW: state_next = ST_CHECK;
      ST_CHECK: state_next = sts.z_en ? ST_MEAN_DIV : ST_OUT;
      ST_MEAN_DIV: state_next = ST_MEAN_WAIT;
      ST_MEAN_WAIT: begin
        if (!sts.div_busy) begin
          state_next = ST_VAR_WAIT;
        end
      end
      ST_VAR_WAIT: begin
        if (!sts.div_busy) begin
          state_next = ST_MSQ;
        end
      end
      ST_MSQ: state_next = ST_VAR;
      ST_VAR: state_next = ST_SQRT_WAIT;
      ST_SQRT_WAIT: begin
        if (!sts.sqrt_busy) begin
          state_next = ST_Z_WAIT;
        end
      end
      ST_Z_WAIT: begin
        if (!sts.div_busy) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: state_next = ST_OUT;
      ST_OUT: begin
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd.op = OP_NONE;
    cmd.sect = sect;
    sample_stall = (state != ST_IDLE) || rst;
    case (state)
      ST_IDLE: cmd.op = sample_valid ? OP_LOAD : OP_NONE;
      ST_SM_MUL1: cmd.op = OP_SM_MUL1;
      ST_SM_MUL2: cmd.op = OP_SM_MUL2;
      ST_SM_DONE: cmd.op = OP_SM_DONE;
      ST_BQ_M0: cmd.op = OP_BQ_M0;
      ST_BQ_Y: cmd.op = OP_BQ_Y;
      ST_BQ_M1: cmd.op = OP_BQ_M1;
      ST_BQ_T1: cmd.op = OP_BQ_T1;
      ST_BQ_M3: cmd.op = OP_BQ_M3;
      ST_BQ_D0: cmd.op = OP_BQ_D0;
      ST_BQ_M2: cmd.op = OP_BQ_M2;
      ST_BQ_T2: cmd.op = OP_BQ_T2;
      ST_BQ_M4: cmd.op = OP_BQ_M4;
      ST_BQ_D1: cmd.op = OP_BQ_D1;
      ST_WIN_RD: cmd.op = OP_WIN_RD;
      ST_SQ_OLD: cmd.op = OP_SQ_OLD;
      ST_SUB_OLD: cmd.op = OP_SUB_OLD;
      ST_SQ_NEW: cmd.op = OP_SQ_NEW;
      ST_ADD_NEW: cmd.op = OP_ADD_NEW;
      ST_MEAN_DIV: cmd.op = OP_MEAN_DIV;
      ST_MEAN_WAIT: cmd.op = sts.div_busy ? OP_NONE : OP_VAR_DIV;
      ST_MSQ: cmd.op = OP_MSQ;
      ST_VAR: cmd.op = OP_VAR;
      ST_SQRT_WAIT: cmd.op = sts.sqrt_busy ? OP_NONE : OP_Z_DIV;
      ST_FINISH: cmd.op = OP_FINISH;
      ST_OUT: cmd.op = out_load ? OP_OUT : OP_NONE;
      default: cmd.op = OP_NONE;
    endcase
  end

endmodule

/* rtl/psbz_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pulse conditioning datapath
// Shared multiplier, filter state, sample window, running sums and z-score.
// ----------------------------------------------------------------------------
module psbz_dp #(
  parameter int WINDOW_DEPTH = 200
) (
  input  logic                 clk,
  input  logic                 rst,
  input  psbz_pkg::psbz_cmd_t  cmd,
  output psbz_pkg::psbz_sts_t  sts,
  input  logic [17:0]          adc_sample,
  input  logic                 cfg_valid,
  input  logic [7:0]           cfg_index,
  input  logic [16:0]          cfg_data,
  output logic signed [23:0]   normalized,
  output logic signed [31:0]   bandpass
);
  import psbz_pkg::*;

  localparam int IDX_W = $clog2(WINDOW_DEPTH);
  localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);
  localparam int SUM_W = 33 + IDX_W;
  localparam int CMP_W = (CNT_W > 8) ? CNT_W : 8;

  logic [16:0] alpha;
  logic [7:0] min_samples;
  logic [29:0] x;
  logic [30:0] prev;
  logic started;
  logic signed [31:0] sig;
  logic signed [31:0] y;
  logic signed [39:0] dly [SECTION_COUNT][2];
  logic signed [47:0] t;
  logic signed [63:0] prod;
  logic [47:0] acc;
  logic signed [31:0] mem [WINDOW_DEPTH];
  logic signed [31:0] rd;
  logic [IDX_W-1:0] wpos;
  logic [CNT_W-1:0] fill;
  logic signed [SUM_W-1:0] sum;
  logic [63:0] sq;
  logic [31:0] mm;
  logic sum_neg;
  logic [63:0] q2;
  logic d_neg;
  logic signed [23:0] zval;

  logic [16:0] alpha_c;
  logic [16:0] beta;
  logic signed [29:0] cb0, cb1, cb2, ca1, ca2;
  logic [31:0] mag_rd;
  logic [31:0] mag_sig;
  logic signed [35:0] rnd_p;
  logic signed [32:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [65:0] mul_full;
  logic signed [47:0] y_sum;
  logic [48:0] sm_sum;
  logic full;
  logic [SUM_W-1:0] sum_mag;
  logic signed [32:0] mean;
  logic signed [64:0] var_diff;
  logic [55:0] var_v;
  logic signed [33:0] diff_d;
  logic [33:0] mag_d;
  logic [63:0] z_dvd;
  logic z_en;

  logic div_start;
  logic [63:0] div_dvd;
  logic [31:0] div_dvs;
  logic [63:0] div_quot;
  logic div_busy;
  logic sqrt_start;
  logic [31:0] sq_root;
  logic sqrt_busy;

  psbz_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(div_dvd),
    .divisor(div_dvs), .quotient(div_quot), .busy(div_busy)
  );

  psbz_sqrt u_sqrt (
    .clk(clk), .rst(rst), .start(sqrt_start), .value({var_v, 8'b0}),
    .root(sq_root), .busy(sqrt_busy)
  );

  assign alpha_c = (alpha > 17'd65536) ? 17'd65536 : alpha;
  assign beta = 17'd65536 - alpha_c;
  assign cb0 = COEF[cmd.sect][COEF_B0];
  assign cb1 = COEF[cmd.sect][COEF_B1];
  assign cb2 = COEF[cmd.sect][COEF_B2];
  assign ca1 = COEF[cmd.sect][COEF_A1];
  assign ca2 = COEF[cmd.sect][COEF_A2];
  assign mag_rd = rd[31] ? 32'(-rd) : 32'(rd);
  assign mag_sig = sig[31] ? 32'(-sig) : 32'(sig);
  assign rnd_p = round_q28(prod);
  assign y_sum = 48'(rnd_p) + 48'(dly[cmd.sect][0]);
  assign sm_sum = {1'b0, acc} + {1'b0, prod[47:0]} + 49'd32768;
  assign full = (fill == CNT_W'(WINDOW_DEPTH));
  assign sum_mag = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
  assign mean = sum_neg ? -$signed({1'b0, mm}) : $signed({1'b0, mm});
  assign var_diff = $signed({1'b0, q2}) - $signed({9'b0, prod[63:8]});
  assign var_v = (var_diff < 65'sd1) ? 56'd1 : var_diff[55:0];
  assign diff_d = 34'(sig) - 34'(mean);
  assign mag_d = diff_d[33] ? 34'(-diff_d) : 34'(diff_d);
  assign z_dvd = {14'b0, mag_d, 16'b0} + {33'b0, sq_root[31:1]};
  assign z_en = CMP_W'(fill) >= CMP_W'(min_samples);

  assign sts.started = started;
  assign sts.z_en = z_en;
  assign sts.div_busy = div_busy;
  assign sts.sqrt_busy = sqrt_busy;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      OP_SM_MUL1: begin
        mul_a = $signed({16'b0, alpha_c});
        mul_b = $signed({3'b0, x});
      end
      OP_SM_MUL2: begin
        mul_a = $signed({16'b0, beta});
        mul_b = $signed({2'b0, prev});
      end
      OP_BQ_M0: begin
        mul_a = 33'(cb0);
        mul_b = 33'(sig);
      end
      OP_BQ_M1: begin
        mul_a = 33'(cb1);
        mul_b = 33'(sig);
      end
      OP_BQ_M2: begin
        mul_a = 33'(cb2);
        mul_b = 33'(sig);
      end
      OP_BQ_M3: begin
        mul_a = 33'(ca1);
        mul_b = 33'(y);
      end
      OP_BQ_M4: begin
        mul_a = 33'(ca2);
        mul_b = 33'(y);
      end
      OP_SQ_OLD: begin
        mul_a = $signed({1'b0, mag_rd});
        mul_b = $signed({1'b0, mag_rd});
      end
      OP_SQ_NEW: begin
        mul_a = $signed({1'b0, mag_sig});
        mul_b = $signed({1'b0, mag_sig});
      end
      OP_MSQ: begin
        mul_a = $signed({1'b0, mm});
        mul_b = $signed({1'b0, mm});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_full = mul_a * mul_b;

  always_comb begin
    div_start = 1'b0;
    div_dvd = sq;
    div_dvs = 32'(fill);
    sqrt_start = (cmd.op == OP_VAR);
    case (cmd.op)
      OP_MEAN_DIV: begin
        div_start = 1'b1;
        div_dvd = 64'(sum_mag) + 64'(fill >> 1);
      end
      OP_VAR_DIV: begin
        div_start = 1'b1;
        div_dvd = sq;
      end
      OP_Z_DIV: begin
        div_start = 1'b1;
        div_dvd = z_dvd;
        div_dvs = sq_root;
      end
      default: div_start = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_SQ_NEW) begin
      mem[wpos] <= sig;
    end
    if (cmd.op == OP_WIN_RD) begin
      rd <= mem[wpos];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      alpha <= 17'd16384;
      min_samples <= 8'd25;
      prev <= '0;
      started <= 1'b0;
      for (int s = 0; s < SECTION_COUNT; s++) begin
        dly[s][0] <= '0;
        dly[s][1] <= '0;
      end
      wpos <= '0;
      fill <= '0;
      sum <= '0;
      sq <= '0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          REG_SMOOTHING_ALPHA: alpha <= cfg_data;
          REG_MIN_SAMPLES: min_samples <= cfg_data[7:0];
          default: ;
        endcase
      end
      case (cmd.op)
        OP_LOAD: begin
          x <= {adc_sample, 12'b0};
          if (!started) begin
            prev <= {1'b0, adc_sample, 12'b0};
            sig <= $signed({2'b0, adc_sample, 12'b0});
            started <= 1'b1;
          end
        end
        OP_SM_MUL1, OP_BQ_M0, OP_BQ_M1, OP_BQ_M2, OP_BQ_M3, OP_BQ_M4,
        OP_SQ_OLD, OP_SQ_NEW: begin
          prod <= mul_full[63:0];
        end
        OP_SM_MUL2: begin
          acc <= prod[47:0];
          prod <= mul_full[63:0];
        end
        OP_SM_DONE: begin
          prev <= sm_sum[46:16];
          sig <= $signed({1'b0, sm_sum[46:16]});
        end
        OP_BQ_Y: y <= sat_to_32(y_sum);
        OP_BQ_T1: t <= 48'(rnd_p) + 48'(dly[cmd.sect][1]);
        OP_BQ_D0: dly[cmd.sect][0] <= sat_to_40(t - 48'(rnd_p));
        OP_BQ_T2: t <= 48'(rnd_p);
        OP_BQ_D1: begin
          dly[cmd.sect][1] <= sat_to_40(t - 48'(rnd_p));
          sig <= y;
        end
        OP_SUB_OLD: begin
          if (full) begin
            sum <= sum - SUM_W'(rd);
            sq <= sq - {8'b0, prod[63:8]};
          end
        end
        OP_ADD_NEW: begin
          sum <= sum + SUM_W'(sig);
          sq <= sq + {8'b0, prod[63:8]};
          if (!full) begin
            fill <= fill + 1'b1;
          end
          wpos <= (wpos == IDX_W'(WINDOW_DEPTH - 1)) ? '0 : wpos + 1'b1;
        end
        OP_VAR_DIV: begin
          mm <= div_quot[31:0];
          sum_neg <= sum[SUM_W-1];
        end
        OP_MSQ: begin
          q2 <= div_quot;
          prod <= mul_full[63:0];
        end
        OP_Z_DIV: d_neg <= diff_d[33];
        OP_FINISH: begin
          if (!d_neg) begin
            zval <= (div_quot >= 64'd8388607) ? 24'sh7FFFFF : $signed(div_quot[23:0]);
          end else begin
            zval <= (div_quot >= 64'd8388608) ? 24'sh800000 :
                    24'(-$signed({1'b0, div_quot[23:0]}));
          end
        end
        OP_OUT: begin
          normalized <= z_en ? zval : '0;
          bandpass <= sig;
        end
        default: ;
      endcase
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= CNT_W'(WINDOW_DEPTH))
    else $error("window fill exceeds the window depth");

  a_wpos_bound: assert property (@(posedge clk) disable iff (rst)
    wpos <= IDX_W'(WINDOW_DEPTH - 1))
    else $error("write position outside the window");

  a_div_idle: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_busy)
    else $error("divider started while busy");

  a_sd_nonzero: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_Z_DIV) |-> (sq_root != 32'd0 && !sqrt_busy))
    else $error("z-score divide issued with a zero deviation");

endmodule

/* rtl/ppg_smooth_bandpass_zscore_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pulse sample smoothing, band-pass and sliding z-score
// Top level joining the sequence controller and the arithmetic datapath.
// ----------------------------------------------------------------------------
// Each raw sample is smoothed by an exponential average, filtered by two
// biquad sections (low-pass, then high-pass), and z-scored against the last
// WINDOW_DEPTH band-pass values; every item gives one result with both the
// band-pass value and the z-score. The block works on one item at a time.
// An accepted item holds the block through the smoothing, filter and window
// steps, and also through the z-score steps once the window holds at least
// min_samples values, before the next item can be taken; the first item after
// reset skips the smoothing steps, and a stalled result holds the block until
// it is taken. The z-score path is set by the single bit-serial divider, which
// runs three 64-step divisions per item, and by the 32-step square root unit.
// The window store is not cleared after reset and needs no clearing pass.
module ppg_smooth_bandpass_zscore_core #(
  parameter int WINDOW_DEPTH = 200
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               sample_valid,
  output logic               sample_stall,
  input  logic [17:0]        adc_sample,
  output logic               result_valid,
  input  logic               result_stall,
  output logic signed [23:0] normalized,
  output logic signed [31:0] bandpass,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [7:0]         cfg_index,
  input  logic [16:0]        cfg_data
);
  import psbz_pkg::*;

  psbz_cmd_t cmd;
  psbz_sts_t sts;

  assign cfg_ready = !rst;

  psbz_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .sample_valid(sample_valid), .sample_stall(sample_stall),
    .result_valid(result_valid), .result_stall(result_stall),
    .sts(sts), .cmd(cmd)
  );

  psbz_dp #(.WINDOW_DEPTH(WINDOW_DEPTH)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts),
    .adc_sample(adc_sample),
    .cfg_valid(cfg_valid && cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .normalized(normalized), .bandpass(bandpass)
  );

endmodule
